// File: rtl/apmw_pkg.sv
// Shared constants, codes and types for the audio peak meter with capture watchdog.
package apmw_pkg;

  // Geometry
  localparam int CHANNELS    = 4;
  localparam int CH_W        = $clog2(CHANNELS);
  localparam int SAMPLE_BITS = 24;
  localparam int NORM_W      = $clog2(SAMPLE_BITS);

  // Log arithmetic
  localparam int LOG_FRAC_BITS = 16;
  localparam int SQ_CNT_W      = $clog2(LOG_FRAC_BITS);
  localparam int X_W           = 31;                      // Q1.30 mantissa
  localparam int MAG_W         = NORM_W + LOG_FRAC_BITS;  // -log2 in Q.16
  localparam int SCALE_W       = 23;
  localparam logic [SCALE_W-1:0] DB_SCALE_Q16 = 23'd6313022;
  localparam int PROD_W        = MAG_W + SCALE_W;
  localparam int LEVEL_W       = 13;
  localparam int DB_MAX        = 4096;

  // Word fields
  localparam int MODE_W  = 3;
  localparam int WORD_W  = 32;
  localparam int LIMIT_W = 16;
  localparam int ERR_W   = 32;
  localparam int CFG_W   = 16;

  // Input mode codes
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HALF   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ERROR  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

  // Configuration register indexes
  localparam logic REG_STALL_LIMIT   = 1'b0;
  localparam logic REG_SILENCE_LEVEL = 1'b1;

  // Reset values of the configuration registers
  localparam logic [LIMIT_W-1:0] STALL_LIMIT_RST   = 16'd30;
  localparam logic [LEVEL_W-1:0] SILENCE_LEVEL_RST = 13'h1A60; // -1440

  // Result kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_LEVEL = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_NORM,
    ST_SQUARE,
    ST_MAG,
    ST_MUL,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic            accept;  // input word taken this cycle
    logic            load;    // fetch and clear peak of ch
    logic            norm;    // normalize peak into mantissa
    logic            square;  // one log2 fraction bit
    logic            mag;     // form -log2 magnitude
    logic            mul;     // scale to dB
    logic            emit;    // load level report into output
    logic [CH_W-1:0] ch;
    logic            last;
  } cmd_t;

endpackage

// File: rtl/audio_peak_meter_watchdog_top.sv
// Top level of the audio peak meter with capture watchdog.
// Four-channel peak meter and capture watchdog. Sample, half-buffer and
// sync-error words give no result; a service tick gives one result word.
// A read word gives four level reports (last one flagged) and holds the
// input until all four are out, plus any output stall: each level needs
// one fetch, one normalize, sixteen passes through the shared 31x31
// squaring multiplier for the log2 fraction, then one magnitude and one
// dB-scaling multiply. A word that gives a result waits while the output
// register is still full and stalled; other words do not wait on the output,
// but no word is taken while a read is in progress. Configuration writes take
// effect at once and are meant for idle periods.
module audio_peak_meter_watchdog_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [apmw_pkg::MODE_W-1:0]         mode,
  input  logic [1:0]                          channel,
  input  logic [apmw_pkg::WORD_W-1:0]         slot_word,
  input  logic                                wr_en,
  input  logic                                wr_index,
  input  logic [apmw_pkg::CFG_W-1:0]          wr_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                result_kind,
  output logic [1:0]                          out_channel,
  output logic signed [apmw_pkg::LEVEL_W-1:0] level_db,
  output logic                                restart,
  output logic [apmw_pkg::ERR_W-1:0]          error_total,
  output logic                                last
);
  import apmw_pkg::*;

  cmd_t cmd;
  logic out_free;

  apmw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .out_free (out_free),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  apmw_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .channel     (channel),
    .slot_word   (slot_word),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .out_stall   (out_stall),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .result_kind (result_kind),
    .out_channel (out_channel),
    .level_db    (level_db),
    .restart     (restart),
    .error_total (error_total),
    .last        (last)
  );

endmodule

// File: rtl/apmw_ctrl.sv
// Controller: input handshake and sequencing of the per-channel level computation.
module apmw_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [apmw_pkg::MODE_W-1:0]  mode,
  input  logic                         out_free,
  output logic                         in_stall,
  output apmw_pkg::cmd_t               cmd
);
  import apmw_pkg::*;

  state_t                state, state_next;
  logic [CH_W-1:0]       ch, ch_next;
  logic [SQ_CNT_W-1:0]   cnt, cnt_next;
  logic                  gives_result;
  logic                  ch_last;

  assign gives_result = (mode == MODE_TICK) || (mode == MODE_READ);
  assign ch_last      = (ch == CH_W'(CHANNELS - 1));

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ch    <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ch_next    = ch;
    cnt_next   = cnt;
    in_stall   = 1'b1;
    cmd        = '0;
    cmd.ch     = ch;
    cmd.last   = ch_last;
    unique case (state)
      ST_IDLE: begin
        in_stall   = gives_result && !out_free;
        cmd.accept = in_valid && !in_stall;
        if (cmd.accept && mode == MODE_READ) begin
          ch_next    = '0;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        cmd.norm   = 1'b1;
        cnt_next   = '0;
        state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == SQ_CNT_W'(LOG_FRAC_BITS - 1)) begin
          state_next = ST_MAG;
        end
      end
      ST_MAG: begin
        cmd.mag    = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          if (ch_last) begin
            state_next = ST_IDLE;
          end else begin
            ch_next    = ch + 1'b1;
            state_next = ST_LOAD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/apmw_datapath.sv
// Datapath: peak registers, watchdog counters, log-level unit and output register.
module apmw_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  apmw_pkg::cmd_t                      cmd,
  input  logic [apmw_pkg::MODE_W-1:0]         mode,
  input  logic [1:0]                          channel,
  input  logic [apmw_pkg::WORD_W-1:0]         slot_word,
  input  logic                                wr_en,
  input  logic                                wr_index,
  input  logic [apmw_pkg::CFG_W-1:0]          wr_data,
  input  logic                                out_stall,
  output logic                                out_free,
  output logic                                out_valid,
  output logic                                result_kind,
  output logic [1:0]                          out_channel,
  output logic signed [apmw_pkg::LEVEL_W-1:0] level_db,
  output logic                                restart,
  output logic [apmw_pkg::ERR_W-1:0]          error_total,
  output logic                                last
);
  import apmw_pkg::*;

  // Configuration
  logic [LIMIT_W-1:0]     stall_limit;
  logic [LEVEL_W-1:0]     silence_level;

  // Meter and watchdog state
  logic [SAMPLE_BITS-1:0] peak_hold [CHANNELS];
  logic [ERR_W-1:0]       error_counter;
  logic                   restart_pending;
  logic                   activity_seen;
  logic [LIMIT_W-1:0]     stall_ticks;

  // Level unit registers
  logic [SAMPLE_BITS-1:0] p;
  logic [NORM_W-1:0]      n;
  logic [X_W-1:0]         x;
  logic [LOG_FRAC_BITS-1:0] frac;
  logic [MAG_W-1:0]       mag;
  logic [PROD_W-1:0]      prod;

  // Peak access: one address, sample channel or sequenced channel
  logic [CH_W-1:0]        addr;
  logic [SAMPLE_BITS-1:0] peak_rd;
  logic [SAMPLE_BITS-1:0] samp;
  logic [SAMPLE_BITS-1:0] samp_abs;
  logic                   samp_ok;

  assign addr     = cmd.load ? cmd.ch : CH_W'(channel);
  assign peak_rd  = peak_hold[addr];
  assign samp     = slot_word[SAMPLE_BITS-1:0];
  assign samp_abs = samp[SAMPLE_BITS-1] ? (~samp + 1'b1) : samp;
  assign samp_ok  = (int'(channel) < CHANNELS);

  // Service tick decision
  logic [LIMIT_W-1:0] ticks_inc;
  logic [LIMIT_W-1:0] tick_ticks;
  logic               tick_rs;

  assign ticks_inc = stall_ticks + 1'b1;

  always_comb begin
    tick_ticks = '0;
    tick_rs    = 1'b0;
    priority if (restart_pending) begin
      tick_rs = 1'b1;
    end else if (!activity_seen) begin
      if (ticks_inc >= stall_limit) begin
        tick_rs = 1'b1;
      end else begin
        tick_ticks = ticks_inc;
      end
    end else begin
      tick_ticks = '0;
    end
  end

  logic ev_sample, ev_half, ev_error, ev_tick;
  assign ev_sample = cmd.accept && mode == MODE_SAMPLE;
  assign ev_half   = cmd.accept && mode == MODE_HALF;
  assign ev_error  = cmd.accept && mode == MODE_ERROR;
  assign ev_tick   = cmd.accept && mode == MODE_TICK;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stall_limit   <= STALL_LIMIT_RST;
      silence_level <= SILENCE_LEVEL_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_STALL_LIMIT:   stall_limit   <= wr_data[LIMIT_W-1:0];
        REG_SILENCE_LEVEL: silence_level <= wr_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Peak hold: max on samples, clear on fetch or restart
  always_ff @(posedge clk) begin
    if (rst || (ev_tick && tick_rs)) begin
      for (int i = 0; i < CHANNELS; i++) begin
        peak_hold[i] <= '0;
      end
    end else if (cmd.load) begin
      peak_hold[addr] <= '0;
    end else if (ev_sample && samp_ok && samp_abs > peak_rd) begin
      peak_hold[addr] <= samp_abs;
    end
  end

  // Watchdog state
  always_ff @(posedge clk) begin
    if (rst) begin
      error_counter   <= '0;
      restart_pending <= 1'b0;
      activity_seen   <= 1'b0;
      stall_ticks     <= '0;
    end else begin
      if (ev_half) begin
        activity_seen <= 1'b1;
      end
      if (ev_error) begin
        if (error_counter != '1) begin
          error_counter <= error_counter + 1'b1;
        end
        restart_pending <= 1'b1;
      end
      if (ev_tick) begin
        stall_ticks <= tick_ticks;
        if (restart_pending) begin
          restart_pending <= 1'b0;
        end else if (activity_seen) begin
          activity_seen <= 1'b0;
        end
      end
    end
  end

  // Leading-one position of the peak
  logic [NORM_W-1:0] lead;
  always_comb begin
    lead = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      if (p[i]) begin
        lead = NORM_W'(i);
      end
    end
  end

  // Squaring step: x in Q1.30, square back to Q.30
  logic [2*X_W-1:0] sq;
  logic [X_W:0]     sq_q30;
  assign sq     = x * x;
  assign sq_q30 = sq[2*X_W-1:X_W-1];

  // Magnitude and rounding
  logic [NORM_W-1:0] int_part;
  logic [PROD_W:0]   rounded;
  logic [LEVEL_W-1:0] db;
  assign int_part = NORM_W'(SAMPLE_BITS - 1) - n;
  assign rounded  = {1'b0, prod} + (PROD_W+1)'(64'd1 << 31);
  assign db       = (rounded[PROD_W:32] > (PROD_W-31)'(DB_MAX)) ? LEVEL_W'(DB_MAX)
                                                              : rounded[32+LEVEL_W-1:32];

  // Level unit sequencing
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p <= peak_rd;
    end
    if (cmd.norm) begin
      n    <= lead;
      x    <= X_W'({{(X_W-SAMPLE_BITS){1'b0}}, p} << (X_W - 1 - int'(lead)));
      frac <= '0;
    end
    if (cmd.square) begin
      frac <= {frac[LOG_FRAC_BITS-2:0], sq_q30[X_W]};
      x    <= sq_q30[X_W] ? sq_q30[X_W:1] : sq_q30[X_W-1:0];
    end
    if (cmd.mag) begin
      mag <= {int_part, {LOG_FRAC_BITS{1'b0}}} - {{NORM_W{1'b0}}, frac};
    end
    if (cmd.mul) begin
      prod <= mag * DB_SCALE_Q16;
    end
  end

  // Output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ev_tick || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_tick) begin
      result_kind <= KIND_TICK;
      out_channel <= '0;
      level_db    <= '0;
      restart     <= tick_rs;
      error_total <= error_counter;
      last        <= 1'b1;
    end else if (cmd.emit) begin
      result_kind <= KIND_LEVEL;
      out_channel <= 2'(cmd.ch);
      level_db    <= (p == '0) ? silence_level : (LEVEL_W'(0) - db);
      restart     <= 1'b0;
      error_total <= error_counter;
      last        <= cmd.last;
    end
  end

endmodule
